[rtl/tga_rle_image_decoder_unit_assert.svh]
// assertion macros shared by the tga decoder rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef TGA_RLE_IMAGE_DECODER_UNIT_ASSERT_SVH
`define TGA_RLE_IMAGE_DECODER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define TGARLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgarle: implication check failed");
// next-cycle implication, checked out of reset
`define TGARLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgarle: next-cycle check failed");
`else
`define TGARLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TGARLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/tgarle_pkg.sv]
// shared types and constants for the tga truecolor rle decoder
// no dependencies
`default_nettype none

package tgarle_pkg;

    // decoder phases
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_PACKET = 3'd2,
        PH_PIXEL  = 3'd3,
        PH_IGNORE = 3'd4
    } t_phase;

    // result kinds
    typedef enum logic [1:0] {
        KIND_INFO  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // error codes
    typedef enum logic [1:0] {
        ERR_TYPE  = 2'd0,
        ERR_DEPTH = 2'd1,
        ERR_DIMS  = 2'd2,
        ERR_TRUNC = 2'd3
    } t_err;

    // header byte positions
    localparam logic [4:0] HDR_ID_LEN = 5'd0;
    localparam logic [4:0] HDR_TYPE   = 5'd2;
    localparam logic [4:0] HDR_W_LO   = 5'd12;
    localparam logic [4:0] HDR_W_HI   = 5'd13;
    localparam logic [4:0] HDR_H_LO   = 5'd14;
    localparam logic [4:0] HDR_H_HI   = 5'd15;
    localparam logic [4:0] HDR_DEPTH  = 5'd16;
    localparam logic [4:0] HDR_LAST   = 5'd17;

    // header field values
    localparam logic [7:0] TYPE_RAW   = 8'd2;
    localparam logic [7:0] TYPE_RLE   = 8'd10;
    localparam logic [7:0] DEPTH_RGB  = 8'd24;
    localparam logic [7:0] DEPTH_RGBA = 8'd32;
    localparam logic [2:0] BPP_RGB    = 3'd3;
    localparam logic [2:0] BPP_RGBA   = 3'd4;
    localparam logic [2:0] BPP_BAD    = 3'd0;

    // rle packet byte
    localparam logic [7:0] PKT_COUNT_MASK = 8'h7F;
    localparam logic [7:0] PKT_RUN_FLAG   = 8'h80;

    // result queue sizing
    localparam int RQ_DEPTH = 4;
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    // one result transaction
    typedef struct packed {
        t_kind       kind;
        logic [31:0] pixel_value;
        logic [7:0]  repeat_res;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        has_alpha;
        t_err        error_code;
        logic        image_done;
        logic        last_of_item;
    } t_result;

endpackage

`default_nettype wire

[rtl/tga_rle_image_decoder_unit.sv]
// tga truecolor decoder: header check, id skip, raw and rle pixel decode
// depends on tgarle_pkg, tgarle_rq and tga_rle_image_decoder_unit_assert.svh
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  in      | i_in_valid / o_in_stall | i_data_byte, i_end_of_file
//  out     | o_out_valid / i_out_stall | o_kind .. o_last_of_item (one result)
//
// one file byte is taken per cycle while o_in_stall is low; its state update happens at acceptance.
// its results (zero, one or two) show at the output from the next cycle on.
// the 4-slot result queue raises o_in_stall while it holds more than two.
// synchronous reset returns to waiting for a header; so does end of file.

`default_nettype none
`include "tga_rle_image_decoder_unit_assert.svh"

module tga_rle_image_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_file,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_pixel_value,
    output logic [7:0]       o_repeat_res,
    output logic [15:0]      o_image_width,
    output logic [15:0]      o_image_height,
    output logic             o_has_alpha,
    output logic [1:0]       o_error_code,
    output logic             o_image_done,
    output logic             o_last_of_item
);

    tgarle_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_header_index, n_header_index;
    logic [7:0]  r_id_length, n_id_length;
    logic        r_compressed, n_compressed;
    logic        r_type_ok, n_type_ok;
    logic [2:0]  r_bpp, n_bpp;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [7:0]  r_skip, n_skip;
    logic [7:0]  r_packet_left, n_packet_left;
    logic        r_packet_is_run, n_packet_is_run;
    logic [1:0]  r_pbi, n_pbi;
    logic [31:0] r_assembly, n_assembly;
    logic [31:0] r_pixels_left, n_pixels_left;

    logic        accept;
    logic        pop;
    logic        q_full;
    logic        v_main;
    logic        v_trunc;
    logic [1:0]  push_cnt;
    logic [7:0]  pkt_cnt;
    logic [1:0]  pbi_inc;
    logic        pix_complete;
    logic [31:0] asm_cur;
    logic [7:0]  rep_raw;
    logic [7:0]  rep_clip;

    tgarle_pkg::t_result res_main;
    tgarle_pkg::t_result res_trunc;
    tgarle_pkg::t_result push_d0;
    tgarle_pkg::t_result head;

    assign accept = i_in_valid && !o_in_stall;
    assign pop    = o_out_valid && !i_out_stall;

    // per-byte helpers
    assign pkt_cnt      = (i_data_byte & tgarle_pkg::PKT_COUNT_MASK) + 8'd1;
    assign pbi_inc      = r_pbi + 2'd1;
    assign pix_complete = (pbi_inc == 2'd0) || ({1'b0, pbi_inc} >= r_bpp);
    assign asm_cur      = r_assembly | ({24'd0, i_data_byte} << {r_pbi, 3'b000});
    assign rep_raw      = (r_compressed && r_packet_is_run) ? r_packet_left : 8'd1;
    assign rep_clip     = ({24'd0, rep_raw} > r_pixels_left) ? r_pixels_left[7:0] : rep_raw;

    // next state and results for the byte on the input
    always_comb begin
        n_phase         = r_phase;
        n_header_index  = r_header_index;
        n_id_length     = r_id_length;
        n_compressed    = r_compressed;
        n_type_ok       = r_type_ok;
        n_bpp           = r_bpp;
        n_width         = r_width;
        n_height        = r_height;
        n_skip          = r_skip;
        n_packet_left   = r_packet_left;
        n_packet_is_run = r_packet_is_run;
        n_pbi           = r_pbi;
        n_assembly      = r_assembly;
        n_pixels_left   = r_pixels_left;
        res_main        = '0;
        res_trunc       = '0;
        v_main          = 1'b0;

        case (r_phase)
            tgarle_pkg::PH_HEADER: begin
                // capture header fields
                case (r_header_index)
                    tgarle_pkg::HDR_ID_LEN: n_id_length = i_data_byte;
                    tgarle_pkg::HDR_TYPE: begin
                        n_compressed = (i_data_byte == tgarle_pkg::TYPE_RLE);
                        n_type_ok    = (i_data_byte == tgarle_pkg::TYPE_RAW) ||
                                       (i_data_byte == tgarle_pkg::TYPE_RLE);
                    end
                    tgarle_pkg::HDR_W_LO: n_width  = {r_width[15:8], i_data_byte};
                    tgarle_pkg::HDR_W_HI: n_width  = {i_data_byte, r_width[7:0]};
                    tgarle_pkg::HDR_H_LO: n_height = {r_height[15:8], i_data_byte};
                    tgarle_pkg::HDR_H_HI: n_height = {i_data_byte, r_height[7:0]};
                    tgarle_pkg::HDR_DEPTH: begin
                        if (i_data_byte == tgarle_pkg::DEPTH_RGB) begin
                            n_bpp = tgarle_pkg::BPP_RGB;
                        end else if (i_data_byte == tgarle_pkg::DEPTH_RGBA) begin
                            n_bpp = tgarle_pkg::BPP_RGBA;
                        end else begin
                            n_bpp = tgarle_pkg::BPP_BAD;
                        end
                    end
                    default: ;
                endcase

                // last header byte: check and report
                if (r_header_index >= tgarle_pkg::HDR_LAST) begin
                    n_header_index = '0;
                    v_main         = 1'b1;
                    if (!r_type_ok) begin
                        res_main.kind       = tgarle_pkg::KIND_ERROR;
                        res_main.error_code = tgarle_pkg::ERR_TYPE;
                        n_phase             = tgarle_pkg::PH_IGNORE;
                    end else if (r_bpp == tgarle_pkg::BPP_BAD) begin
                        res_main.kind       = tgarle_pkg::KIND_ERROR;
                        res_main.error_code = tgarle_pkg::ERR_DEPTH;
                        n_phase             = tgarle_pkg::PH_IGNORE;
                    end else if (r_width == '0 || r_height == '0) begin
                        res_main.kind       = tgarle_pkg::KIND_ERROR;
                        res_main.error_code = tgarle_pkg::ERR_DIMS;
                        n_phase             = tgarle_pkg::PH_IGNORE;
                    end else begin
                        res_main.kind         = tgarle_pkg::KIND_INFO;
                        res_main.image_width  = r_width;
                        res_main.image_height = r_height;
                        res_main.has_alpha    = (r_bpp == tgarle_pkg::BPP_RGBA);
                        n_pixels_left         = {16'd0, r_width} * {16'd0, r_height};
                        n_skip                = r_id_length;
                        if (r_id_length != '0) begin
                            n_phase = tgarle_pkg::PH_SKIP;
                        end else begin
                            n_pbi         = '0;
                            n_assembly    = '0;
                            n_packet_left = '0;
                            n_phase       = r_compressed ? tgarle_pkg::PH_PACKET
                                                         : tgarle_pkg::PH_PIXEL;
                        end
                    end
                end else begin
                    n_header_index = r_header_index + 5'd1;
                end
            end

            tgarle_pkg::PH_SKIP: begin
                // drop image id bytes
                n_skip = r_skip - 8'd1;
                if (n_skip == '0) begin
                    n_pbi         = '0;
                    n_assembly    = '0;
                    n_packet_left = '0;
                    n_phase       = r_compressed ? tgarle_pkg::PH_PACKET
                                                 : tgarle_pkg::PH_PIXEL;
                end
            end

            tgarle_pkg::PH_PACKET: begin
                // packet header, count clipped to what the image still needs
                n_packet_is_run = (i_data_byte & tgarle_pkg::PKT_RUN_FLAG) != '0;
                n_packet_left   = ({24'd0, pkt_cnt} > r_pixels_left) ? r_pixels_left[7:0]
                                                                     : pkt_cnt;
                n_pbi           = '0;
                n_assembly      = '0;
                n_phase         = tgarle_pkg::PH_PIXEL;
            end

            tgarle_pkg::PH_PIXEL: begin
                // gather pixel bytes, emit on the last one
                if (!pix_complete) begin
                    n_pbi      = pbi_inc;
                    n_assembly = asm_cur;
                end else begin
                    n_pbi = '0;
                    if (r_compressed && r_packet_is_run) begin
                        n_packet_left = '0;
                    end else if (r_compressed && r_packet_left != '0) begin
                        n_packet_left = r_packet_left - 8'd1;
                    end
                    n_pixels_left        = r_pixels_left - {24'd0, rep_clip};
                    v_main               = 1'b1;
                    res_main.kind        = tgarle_pkg::KIND_PIXEL;
                    res_main.pixel_value = asm_cur;
                    res_main.repeat_res  = rep_clip;
                    res_main.image_done  = (n_pixels_left == '0);
                    n_assembly           = '0;
                    if (n_pixels_left == '0) begin
                        n_phase = tgarle_pkg::PH_IGNORE;
                    end else if (r_compressed && n_packet_left == '0) begin
                        n_phase = tgarle_pkg::PH_PACKET;
                    end
                end
            end

            default: ;
        endcase

        // end of file: flag an unfinished image, then start over
        v_trunc                = i_end_of_file && (n_phase != tgarle_pkg::PH_IGNORE);
        res_trunc.kind         = tgarle_pkg::KIND_ERROR;
        res_trunc.error_code   = tgarle_pkg::ERR_TRUNC;
        res_trunc.last_of_item = 1'b1;
        res_main.last_of_item  = !v_trunc;

        if (i_end_of_file) begin
            n_phase         = tgarle_pkg::PH_HEADER;
            n_header_index  = '0;
            n_id_length     = '0;
            n_compressed    = 1'b0;
            n_type_ok       = 1'b0;
            n_bpp           = tgarle_pkg::BPP_RGB;
            n_width         = '0;
            n_height        = '0;
            n_skip          = '0;
            n_packet_left   = '0;
            n_packet_is_run = 1'b0;
            n_pbi           = '0;
            n_assembly      = '0;
            n_pixels_left   = '0;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= tgarle_pkg::PH_HEADER;
            r_header_index  <= '0;
            r_id_length     <= '0;
            r_compressed    <= 1'b0;
            r_type_ok       <= 1'b0;
            r_bpp           <= tgarle_pkg::BPP_RGB;
            r_width         <= '0;
            r_height        <= '0;
            r_skip          <= '0;
            r_packet_left   <= '0;
            r_packet_is_run <= 1'b0;
            r_pbi           <= '0;
            r_assembly      <= '0;
            r_pixels_left   <= '0;
        end else if (accept) begin
            r_phase         <= n_phase;
            r_header_index  <= n_header_index;
            r_id_length     <= n_id_length;
            r_compressed    <= n_compressed;
            r_type_ok       <= n_type_ok;
            r_bpp           <= n_bpp;
            r_width         <= n_width;
            r_height        <= n_height;
            r_skip          <= n_skip;
            r_packet_left   <= n_packet_left;
            r_packet_is_run <= n_packet_is_run;
            r_pbi           <= n_pbi;
            r_assembly      <= n_assembly;
            r_pixels_left   <= n_pixels_left;
        end
    end

    // pack results into the queue, truncation error always last
    assign push_cnt = accept ? ({1'b0, v_main} + {1'b0, v_trunc}) : 2'd0;
    assign push_d0  = v_main ? res_main : res_trunc;

    tgarle_rq u_rq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push_d0  (push_d0),
        .i_push_d1  (res_trunc),
        .i_pop      (pop),
        .o_head     (head),
        .o_valid    (o_out_valid),
        .o_full     (q_full)
    );

    // output port
    assign o_in_stall     = q_full;
    assign o_kind         = head.kind;
    assign o_pixel_value  = head.pixel_value;
    assign o_repeat_res   = head.repeat_res;
    assign o_image_width  = head.image_width;
    assign o_image_height = head.image_height;
    assign o_has_alpha    = head.has_alpha;
    assign o_error_code   = head.error_code;
    assign o_image_done   = head.image_done;
    assign o_last_of_item = head.last_of_item;

    // decoder checks
    `TGARLE_ASSERT_NEXT(a_eof_restart, i_clk, i_rst_n, accept && i_end_of_file, r_phase == tgarle_pkg::PH_HEADER && r_header_index == '0)
    `TGARLE_ASSERT_IMPLY(a_pixels_pending, i_clk, i_rst_n, r_phase == tgarle_pkg::PH_PIXEL || r_phase == tgarle_pkg::PH_PACKET, r_pixels_left != '0)
    `TGARLE_ASSERT_IMPLY(a_pixel_depth, i_clk, i_rst_n, r_phase == tgarle_pkg::PH_PIXEL, r_bpp == tgarle_pkg::BPP_RGB || r_bpp == tgarle_pkg::BPP_RGBA)
    `TGARLE_ASSERT_IMPLY(a_trunc_pushed, i_clk, i_rst_n, accept && v_trunc, push_cnt != 2'd0)

endmodule

`default_nettype wire

[rtl/tgarle_rq.sv]
// result queue: shifting register slots, head slot drives the output port
// depends on tgarle_pkg and tga_rle_image_decoder_unit_assert.svh
`default_nettype none
`include "tga_rle_image_decoder_unit_assert.svh"

module tgarle_rq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [1:0]          i_push_cnt,
    input  wire tgarle_pkg::t_result i_push_d0,
    input  wire tgarle_pkg::t_result i_push_d1,
    input  wire logic                i_pop,
    output tgarle_pkg::t_result      o_head,
    output logic                     o_valid,
    output logic                     o_full
);

    tgarle_pkg::t_result r_slot [tgarle_pkg::RQ_DEPTH];
    tgarle_pkg::t_result n_slot [tgarle_pkg::RQ_DEPTH];
    logic [tgarle_pkg::RQ_CW-1:0] r_count;
    logic [tgarle_pkg::RQ_CW-1:0] n_count;
    logic [tgarle_pkg::RQ_CW-1:0] occ;

    // shift on pop, then drop new transactions behind the survivors
    always_comb begin
        occ = r_count - {{(tgarle_pkg::RQ_CW-1){1'b0}}, i_pop};
        for (int k = 0; k < tgarle_pkg::RQ_DEPTH; k++) begin
            n_slot[k] = r_slot[k];
        end
        if (i_pop) begin
            for (int k = 0; k < tgarle_pkg::RQ_DEPTH - 1; k++) begin
                n_slot[k] = r_slot[k + 1];
            end
        end
        for (int k = 0; k < tgarle_pkg::RQ_DEPTH; k++) begin
            if (i_push_cnt != 2'd0 && tgarle_pkg::RQ_CW'(k) == occ) begin
                n_slot[k] = i_push_d0;
            end
            if (i_push_cnt == 2'd2 &&
                tgarle_pkg::RQ_CW'(k) == occ + tgarle_pkg::RQ_CW'(1)) begin
                n_slot[k] = i_push_d1;
            end
        end
        n_count = occ + tgarle_pkg::RQ_CW'(i_push_cnt);
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < tgarle_pkg::RQ_DEPTH; k++) begin
            r_slot[k] <= n_slot[k];
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = r_slot[0];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count > tgarle_pkg::RQ_CW'(tgarle_pkg::RQ_DEPTH - 2));

    // occupancy checks
    `TGARLE_ASSERT_IMPLY(a_rq_bound, i_clk, i_rst_n, 1'b1, r_count <= tgarle_pkg::RQ_CW'(tgarle_pkg::RQ_DEPTH))
    `TGARLE_ASSERT_IMPLY(a_rq_no_push_full, i_clk, i_rst_n, i_push_cnt != 2'd0, !o_full)
    `TGARLE_ASSERT_IMPLY(a_rq_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `TGARLE_ASSERT_NEXT(a_rq_count_track, i_clk, i_rst_n, 1'b1, r_count == $past(n_count))

endmodule

`default_nettype wire

[tb/tga_rle_image_decoder_unit_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for the tga truecolor rle decoder unit
// depends on tgarle_pkg and tga_rle_image_decoder_unit; builds tga byte streams and
// checks every decoded result against an in-bench decoder model

module tga_rle_image_decoder_unit_test;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_data_byte   = 8'd0;
    logic        i_end_of_file = 1'b0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [31:0] o_pixel_value;
    logic [7:0]  o_repeat_res;
    logic [15:0] o_image_width;
    logic [15:0] o_image_height;
    logic        o_has_alpha;
    logic [1:0]  o_error_code;
    logic        o_image_done;
    logic        o_last_of_item;

    tga_rle_image_decoder_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_file  (i_end_of_file),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_pixel_value  (o_pixel_value),
        .o_repeat_res   (o_repeat_res),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_has_alpha    (o_has_alpha),
        .o_error_code   (o_error_code),
        .o_image_done   (o_image_done),
        .o_last_of_item (o_last_of_item)
    );

    always #4 i_clk = ~i_clk;

    // shared bench state
    tgarle_pkg::t_result decoded_results[$];
    logic [7:0]  file_bytes[$];
    bit          failed;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          hold_len;
    int          hold_req_id;
    int unsigned bytes_sent;

    // decoder model state
    tgarle_pkg::t_phase dec_phase;
    logic [4:0]  hdr_pos;
    logic [7:0]  id_len;
    logic        rle_mode;
    logic [2:0]  px_bytes;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [7:0]  skip_left;
    logic [7:0]  pkt_left;
    logic        pkt_run;
    logic [1:0]  byte_pos;
    logic [31:0] px_acc;
    logic [31:0] px_remaining;
    logic        type_good;

    function automatic void clear_decoder();
        dec_phase    = tgarle_pkg::PH_HEADER;
        hdr_pos      = '0;
        id_len       = '0;
        rle_mode     = 1'b0;
        px_bytes     = tgarle_pkg::BPP_RGB;
        img_w        = '0;
        img_h        = '0;
        skip_left    = '0;
        pkt_left     = '0;
        pkt_run      = 1'b0;
        byte_pos     = '0;
        px_acc       = '0;
        px_remaining = '0;
        type_good    = 1'b0;
    endfunction

    function automatic void start_pixels();
        byte_pos  = '0;
        px_acc    = '0;
        pkt_left  = '0;
        dec_phase = rle_mode ? tgarle_pkg::PH_PACKET : tgarle_pkg::PH_PIXEL;
    endfunction

    function automatic tgarle_pkg::t_result make_result(
        tgarle_pkg::t_kind k, logic [31:0] pix, logic [7:0] rep,
        logic [15:0] w, logic [15:0] h, logic alpha,
        tgarle_pkg::t_err err, logic done);
        tgarle_pkg::t_result r;
        r.kind         = k;
        r.pixel_value  = pix;
        r.repeat_res   = rep;
        r.image_width  = w;
        r.image_height = h;
        r.has_alpha    = alpha;
        r.error_code   = err;
        r.image_done   = done;
        r.last_of_item = 1'b0;
        return r;
    endfunction

    function automatic tgarle_pkg::t_result make_error(tgarle_pkg::t_err err);
        return make_result(tgarle_pkg::KIND_ERROR, '0, '0, '0, '0, 1'b0, err, 1'b0);
    endfunction

    // advance the model by one file byte and queue the results it causes
    function automatic void decode_byte(input logic [7:0] b, input logic eof);
        tgarle_pkg::t_result res[$];
        tgarle_pkg::t_result r;
        logic [8:0]  cnt;
        logic [31:0] rep;
        logic        done;
        case (dec_phase)
            tgarle_pkg::PH_HEADER: begin
                case (hdr_pos)
                    tgarle_pkg::HDR_ID_LEN: id_len = b;
                    tgarle_pkg::HDR_TYPE: begin
                        rle_mode  = (b == tgarle_pkg::TYPE_RLE);
                        type_good = (b == tgarle_pkg::TYPE_RAW) ||
                                    (b == tgarle_pkg::TYPE_RLE);
                    end
                    tgarle_pkg::HDR_W_LO:  img_w[7:0]  = b;
                    tgarle_pkg::HDR_W_HI:  img_w[15:8] = b;
                    tgarle_pkg::HDR_H_LO:  img_h[7:0]  = b;
                    tgarle_pkg::HDR_H_HI:  img_h[15:8] = b;
                    tgarle_pkg::HDR_DEPTH: begin
                        px_bytes = (b == tgarle_pkg::DEPTH_RGB)  ? tgarle_pkg::BPP_RGB :
                                   (b == tgarle_pkg::DEPTH_RGBA) ? tgarle_pkg::BPP_RGBA :
                                                                   tgarle_pkg::BPP_BAD;
                    end
                    default: ;
                endcase
                if (hdr_pos == tgarle_pkg::HDR_LAST) begin
                    hdr_pos = '0;
                    if (!type_good) begin
                        res.push_back(make_error(tgarle_pkg::ERR_TYPE));
                        dec_phase = tgarle_pkg::PH_IGNORE;
                    end else if (px_bytes == tgarle_pkg::BPP_BAD) begin
                        res.push_back(make_error(tgarle_pkg::ERR_DEPTH));
                        dec_phase = tgarle_pkg::PH_IGNORE;
                    end else if (img_w == '0 || img_h == '0) begin
                        res.push_back(make_error(tgarle_pkg::ERR_DIMS));
                        dec_phase = tgarle_pkg::PH_IGNORE;
                    end else begin
                        res.push_back(make_result(tgarle_pkg::KIND_INFO, '0, '0, img_w, img_h,
                                                  px_bytes == tgarle_pkg::BPP_RGBA,
                                                  tgarle_pkg::ERR_TYPE, 1'b0));
                        px_remaining = {16'd0, img_w} * {16'd0, img_h};
                        skip_left    = id_len;
                        if (skip_left != '0) dec_phase = tgarle_pkg::PH_SKIP;
                        else start_pixels();
                    end
                end else begin
                    hdr_pos = hdr_pos + 5'd1;
                end
            end
            tgarle_pkg::PH_SKIP: begin
                skip_left = skip_left - 8'd1;
                if (skip_left == '0) start_pixels();
            end
            tgarle_pkg::PH_PACKET: begin
                cnt       = {1'b0, b & tgarle_pkg::PKT_COUNT_MASK} + 9'd1;
                pkt_run   = (b & tgarle_pkg::PKT_RUN_FLAG) != '0;
                pkt_left  = ({23'd0, cnt} > px_remaining) ? px_remaining[7:0] : cnt[7:0];
                byte_pos  = '0;
                px_acc    = '0;
                dec_phase = tgarle_pkg::PH_PIXEL;
            end
            tgarle_pkg::PH_PIXEL: begin
                px_acc   = px_acc | ({24'd0, b} << {byte_pos, 3'b000});
                byte_pos = byte_pos + 2'd1;
                if (byte_pos == 2'd0 || {1'b0, byte_pos} >= px_bytes) begin
                    byte_pos = '0;
                    // a run pixel carries the whole packet, a literal pixel one
                    if (rle_mode && pkt_run) begin
                        rep      = {24'd0, pkt_left};
                        pkt_left = '0;
                    end else begin
                        rep = 32'd1;
                        if (rle_mode && pkt_left != '0) pkt_left = pkt_left - 8'd1;
                    end
                    if (rep > px_remaining) rep = px_remaining;
                    px_remaining = px_remaining - rep;
                    done = (px_remaining == '0);
                    res.push_back(make_result(tgarle_pkg::KIND_PIXEL, px_acc, rep[7:0],
                                              '0, '0, 1'b0, tgarle_pkg::ERR_TYPE, done));
                    px_acc = '0;
                    if (done) dec_phase = tgarle_pkg::PH_IGNORE;
                    else if (rle_mode && pkt_left == '0) dec_phase = tgarle_pkg::PH_PACKET;
                end
            end
            default: ;
        endcase
        // end of file: flag an unfinished image, then start over
        if (eof) begin
            if (dec_phase != tgarle_pkg::PH_IGNORE)
                res.push_back(make_error(tgarle_pkg::ERR_TRUNC));
            clear_decoder();
        end
        foreach (res[i]) begin
            r = res[i];
            r.last_of_item = (i == res.size() - 1);
            decoded_results.push_back(r);
        end
    endfunction

    // offer one file byte and wait for its transaction
    task automatic push_file_byte(input logic [7:0] b, input logic eof);
        while (tx_idle_on && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_end_of_file <= eof;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_byte(b, eof);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            push_file_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    // sender goes quiet until every expected result has come
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (decoded_results.size() != 0);
    endtask

    // file builders
    task automatic add_header(input logic [7:0] id, input logic [7:0] itype,
                              input logic [15:0] w, input logic [15:0] h,
                              input logic [7:0] depth);
        logic [7:0] hdr[18];
        foreach (hdr[i]) hdr[i] = 8'($urandom_range(255));
        hdr[tgarle_pkg::HDR_ID_LEN] = id;
        hdr[tgarle_pkg::HDR_TYPE]   = itype;
        hdr[tgarle_pkg::HDR_W_LO]   = w[7:0];
        hdr[tgarle_pkg::HDR_W_HI]   = w[15:8];
        hdr[tgarle_pkg::HDR_H_LO]   = h[7:0];
        hdr[tgarle_pkg::HDR_H_HI]   = h[15:8];
        hdr[tgarle_pkg::HDR_DEPTH]  = depth;
        foreach (hdr[i]) file_bytes.push_back(hdr[i]);
    endtask

    task automatic add_random(input int unsigned n);
        repeat (n) file_bytes.push_back(8'($urandom_range(255)));
    endtask

    // random run and literal packets covering npix pixels, sometimes overrunning
    task automatic add_rle_body(input int unsigned npix, input int unsigned bpp);
        int unsigned left;
        int unsigned cnt;
        int unsigned used;
        left = npix;
        while (left > 0) begin
            cnt  = ($urandom_range(4) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
            used = (cnt > left) ? left : cnt;
            if ($urandom_range(1)) begin
                file_bytes.push_back(tgarle_pkg::PKT_RUN_FLAG | 8'(cnt - 1));
                add_random(bpp);
            end else begin
                file_bytes.push_back(8'(cnt - 1));
                add_random(used * bpp);
            end
            left -= used;
        end
    endtask

    // one random file: mostly well formed, some broken headers and early ends
    task automatic send_random_file();
        int unsigned flavor;
        int unsigned bpp;
        int unsigned keep;
        logic [7:0]  itype;
        logic [7:0]  depth;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  id;
        flavor = $urandom_range(99);
        itype  = $urandom_range(1) ? tgarle_pkg::TYPE_RLE : tgarle_pkg::TYPE_RAW;
        depth  = $urandom_range(1) ? tgarle_pkg::DEPTH_RGBA : tgarle_pkg::DEPTH_RGB;
        bpp    = (depth == tgarle_pkg::DEPTH_RGBA) ? 4 : 3;
        w      = 16'($urandom_range(1, 4));
        h      = 16'($urandom_range(1, 3));
        if ($urandom_range(9) == 0) begin
            w = 16'($urandom_range(1, 16));
            h = 16'($urandom_range(1, 8));
        end
        id = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 6)) : 8'd0;
        if (flavor < 4) begin
            do itype = 8'($urandom_range(255));
            while (itype == tgarle_pkg::TYPE_RAW || itype == tgarle_pkg::TYPE_RLE);
        end else if (flavor < 8) begin
            do depth = 8'($urandom_range(255));
            while (depth == tgarle_pkg::DEPTH_RGB || depth == tgarle_pkg::DEPTH_RGBA);
        end else if (flavor < 11) begin
            if ($urandom_range(1)) w = 16'd0;
            else h = 16'd0;
            if ($urandom_range(3) == 0) h = 16'd0;
        end else if (flavor < 14) begin
            w = 16'($urandom_range(65535));
            h = 16'($urandom_range(1, 65535));
            w[15] = 1'($urandom_range(1));
            if (w == 16'd0) w = 16'hFFFF;
        end
        add_header(id, itype, w, h, depth);
        if (flavor < 11) begin
            add_random($urandom_range(5));
        end else if (flavor < 14) begin
            add_random(id + $urandom_range(20));
        end else begin
            add_random(id);
            if (itype == tgarle_pkg::TYPE_RLE) add_rle_body({16'd0, w} * {16'd0, h}, bpp);
            else add_random({16'd0, w} * {16'd0, h} * bpp);
            add_random($urandom_range(3));
        end
        // cut the stream short now and then
        if (flavor >= 11 && flavor < 22) begin
            keep = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > keep) void'(file_bytes.pop_back());
        end
        send_file();
    endtask

    // test tasks
    task automatic test_raw_images();
        add_header(8'd0, tgarle_pkg::TYPE_RAW, 16'd1, 16'd1, tgarle_pkg::DEPTH_RGB);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        add_random(2);
        send_file();
        add_header(8'd3, tgarle_pkg::TYPE_RAW, 16'd2, 16'd1, tgarle_pkg::DEPTH_RGBA);
        add_random(3);
        repeat (4) file_bytes.push_back(8'h00);
        repeat (4) file_bytes.push_back(8'hFF);
        send_file();
    endtask

    task automatic test_rle_packets();
        // longest run clipped to a 2x2 image
        add_header(8'd0, tgarle_pkg::TYPE_RLE, 16'd2, 16'd2, tgarle_pkg::DEPTH_RGB);
        file_bytes.push_back(tgarle_pkg::PKT_RUN_FLAG | tgarle_pkg::PKT_COUNT_MASK);
        file_bytes.push_back(8'hAA);
        file_bytes.push_back(8'h55);
        file_bytes.push_back(8'hAA);
        add_random(1);
        send_file();
        // literal, single run, then longest literal clipped
        add_header(8'd1, tgarle_pkg::TYPE_RLE, 16'd3, 16'd2, tgarle_pkg::DEPTH_RGBA);
        add_random(1);
        file_bytes.push_back(8'h02);
        add_random(12);
        file_bytes.push_back(tgarle_pkg::PKT_RUN_FLAG);
        add_random(4);
        file_bytes.push_back(tgarle_pkg::PKT_COUNT_MASK);
        add_random(8);
        send_file();
    endtask

    task automatic test_header_errors();
        add_header(8'd0, 8'd3, 16'd1, 16'd1, 8'd16);
        add_random(3);
        send_file();
        add_header(8'd0, tgarle_pkg::TYPE_RAW, 16'd1, 16'd1, 8'd16);
        send_file();
        add_header(8'd0, tgarle_pkg::TYPE_RLE, 16'd0, 16'd5, tgarle_pkg::DEPTH_RGB);
        add_random(1);
        send_file();
        add_header(8'd0, tgarle_pkg::TYPE_RLE, 16'd5, 16'd0, tgarle_pkg::DEPTH_RGBA);
        send_file();
    endtask

    task automatic test_early_end();
        add_random(1);
        send_file();
        add_header(8'd0, tgarle_pkg::TYPE_RAW, 16'd1, 16'd1, tgarle_pkg::DEPTH_RGB);
        while (file_bytes.size() > 10) void'(file_bytes.pop_back());
        send_file();
        add_header(8'd4, tgarle_pkg::TYPE_RAW, 16'd1, 16'd1, tgarle_pkg::DEPTH_RGB);
        add_random(2);
        send_file();
        // image info and truncation on the same byte
        add_header(8'd0, tgarle_pkg::TYPE_RAW, 16'd1, 16'd1, tgarle_pkg::DEPTH_RGB);
        send_file();
        add_header(8'd0, tgarle_pkg::TYPE_RLE, 16'd2, 16'd1, tgarle_pkg::DEPTH_RGBA);
        file_bytes.push_back(8'h81);
        send_file();
        add_header(8'd0, tgarle_pkg::TYPE_RLE, 16'd2, 16'd1, tgarle_pkg::DEPTH_RGBA);
        file_bytes.push_back(8'h81);
        add_random(2);
        send_file();
    endtask

    task automatic test_largest_fields();
        add_header(8'hFF, tgarle_pkg::TYPE_RLE, 16'hFFFF, 16'hFFFF, tgarle_pkg::DEPTH_RGBA);
        add_random(255);
        file_bytes.push_back(tgarle_pkg::PKT_RUN_FLAG | tgarle_pkg::PKT_COUNT_MASK);
        add_random(4);
        file_bytes.push_back(tgarle_pkg::PKT_COUNT_MASK);
        add_random(8);
        send_file();
    endtask

    // receiver holds off while bytes keep coming, then the sender waits for all results
    task automatic test_backpressure();
        drain();
        hold_len = 150;
        hold_req_id++;
        add_header(8'd0, tgarle_pkg::TYPE_RAW, 16'd8, 16'd4, tgarle_pkg::DEPTH_RGB);
        add_random(8 * 4 * 3);
        send_file();
        drain();
    endtask

    task automatic test_no_idling();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (5) send_random_file();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_files();
        while (bytes_sent < 1200) send_random_file();
    endtask

    // receiver stall: long hold when asked, else random while rx_idle_on is set, else none
    always @(posedge i_clk) begin
        int hold_seen;
        int hold_left;
        if (hold_req_id != hold_seen) begin
            hold_seen = hold_req_id;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_idle_on) begin
            i_out_stall <= ($urandom_range(99) < 10);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // compare each result transaction with the oldest expected one
    always @(posedge i_clk) begin
        tgarle_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_results.size() == 0) begin
                $error("unexpected result: kind %0d", o_kind);
                failed = 1'b1;
            end else begin
                want = decoded_results.pop_front();
                check_field("kind", {30'd0, want.kind}, {30'd0, o_kind});
                check_field("pixel_value", want.pixel_value, o_pixel_value);
                check_field("repeat_res", {24'd0, want.repeat_res}, {24'd0, o_repeat_res});
                check_field("image_width", {16'd0, want.image_width}, {16'd0, o_image_width});
                check_field("image_height", {16'd0, want.image_height},
                            {16'd0, o_image_height});
                check_field("has_alpha", {31'd0, want.has_alpha}, {31'd0, o_has_alpha});
                check_field("error_code", {30'd0, want.error_code}, {30'd0, o_error_code});
                check_field("image_done", {31'd0, want.image_done}, {31'd0, o_image_done});
                check_field("last_of_item", {31'd0, want.last_of_item},
                            {31'd0, o_last_of_item});
            end
        end
    end

    // main sequence
    initial begin
        clear_decoder();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_raw_images();
        test_rle_packets();
        test_header_errors();
        test_early_end();
        test_largest_fields();
        test_backpressure();
        test_no_idling();
        test_random_files();
        drain();
        repeat (16) @(posedge i_clk);
        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run limit
    initial begin
        #3_200_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
